// ===== sv/pts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the periodic timer scheduler.
// No dependencies; every other file imports this package.
package pts_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_WAIT   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [30:0] NO_TIMER_WAIT = 31'd1000;
    localparam logic [30:0] WAIT_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] timer_id;
        logic [31:0] period_ms;
        logic [63:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fired_id;
        logic [30:0] wait_ms;
        logic [1:0]  status;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        SM_ADD,
        SM_REMOVE,
        SM_REARM,
        SM_DEDUP,
        SM_TWIN,
        SM_FIRE,
        SM_WAIT
    } scan_mode_t;

    typedef enum logic [1:0] {
        SRC_STATUS,
        SRC_FIRE,
        SRC_WAIT,
        SRC_ONE
    } emit_src_t;

    typedef struct packed {
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       emit;
        emit_src_t  emit_src;
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
        logic       emit_last;
        logic       commit_add;
        logic       commit_remove;
        logic       fire_update;
        logic       prev_update;
    } cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       add_ok;
        logic       skew;
        logic       out_free;
        logic [1:0] func;
    } sts_t;

endpackage

// ===== sv/periodic_timer_scheduler.sv =====
`timescale 1ns / 1ps
// Channel  Handshake             Word
// in       in_valid / in_stall   in_word  (func, timer_id, period_ms, now_ms)
// out      out_valid / out_stall out_word (kind, fired_id, wait_ms, status, last)
//
// One word is worked at a time; each pass over the slot store goes through the single
// read port of the slot memory.
// Add and remove make one pass each; a tick makes a find pass and a twin pass per fire
// and ends with a find pass that finds none (skipped once the fire cap is hit) and a wait
// pass, and a backward clock jump makes the re-arm pass and then the duplicate sweep,
// one pass per slot that starts at that slot.
// Reset clears all slots at once; out_stall holds results in the output register.
// Depends on pts_pkg, pts_ctrl and pts_dp.
module periodic_timer_scheduler
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int MAX_FIRES   = 31
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int IDX_W    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int FIRE_CAP = (MAX_FIRES < 31) ? MAX_FIRES : 31;

    logic             idle;
    logic             in_accept;
    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] scan_base;

    assign in_stall  = !idle;
    assign in_accept = in_valid && idle;

    pts_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .FIRE_CAP    (FIRE_CAP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .sts       (sts),
        .idle      (idle),
        .cmd       (cmd),
        .scan_base (scan_base)
    );

    pts_dp #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .in_accept (in_accept),
        .cmd       (cmd),
        .scan_base (scan_base),
        .sts       (sts),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

// ===== sv/pts_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the timer scheduler: slot store, scan engine, best/hold registers
// and the result register. Depends on pts_pkg; driven by pts_ctrl.
module pts_dp
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  in_word_t                in_word,
    input  logic                    in_accept,
    input  cmd_t                    cmd,
    input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] scan_base,
    output sts_t                    sts,
    output out_word_t               out_word,
    output logic                    out_valid,
    input  logic                    out_stall
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    logic [1:0]  in_func_reg;
    logic [31:0] in_id_reg;
    logic [31:0] in_period_reg;
    logic [63:0] in_now_reg;
    logic [63:0] key_trig_reg;
    logic [63:0] prev_now_reg;

    logic [31:0] id_mem     [TIMER_SLOTS];
    logic [31:0] period_mem [TIMER_SLOTS];
    logic [63:0] trig_mem   [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] valid_reg;

    logic             run_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] base_reg;
    scan_mode_t       mode_reg;
    logic             pv_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic [31:0]      rd_id_reg;
    logic [31:0]      rd_period_reg;
    logic [63:0]      rd_trig_reg;

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_id_reg;
    logic [31:0]      best_period_reg;
    logic [63:0]      best_trig_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             hold_valid_reg;
    logic [IDX_W-1:0] hold_idx_reg;
    logic [31:0]      hold_id_reg;
    logic [63:0]      hold_trig_reg;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic             p_valid;
    logic             twin_match;
    logic             take_best;
    logic             take_free;
    logic             clear_p;
    logic             rearm_p;
    logic             load_hold;
    logic [63:0]      fire_trig_next;
    logic [IDX_W-1:0] add_idx;
    logic             trig_we;
    logic [IDX_W-1:0] wr_idx;
    logic [63:0]      wr_trig;
    logic [63:0]      wait_diff;
    out_word_t        emit_word;

    assign p_valid        = valid_reg[pidx_reg];
    assign fire_trig_next = best_trig_reg + {32'd0, best_period_reg};
    assign add_idx        = found_reg ? best_idx_reg : free_idx_reg;
    assign twin_match     = pv_reg && p_valid && hold_valid_reg && (pidx_reg != hold_idx_reg)
                            && (rd_id_reg == hold_id_reg) && (rd_trig_reg == hold_trig_reg);

    always_comb
    begin
        take_best = 1'b0;
        take_free = 1'b0;
        clear_p   = 1'b0;
        rearm_p   = 1'b0;
        load_hold = 1'b0;
        case (mode_reg)
            SM_ADD:
            begin
                take_best = pv_reg && p_valid && !found_reg && (rd_id_reg == in_id_reg)
                            && (rd_trig_reg == key_trig_reg);
                take_free = pv_reg && !p_valid && !free_found_reg;
            end
            SM_REMOVE:
            begin
                take_best = pv_reg && p_valid && (rd_id_reg == in_id_reg)
                            && (!found_reg || (rd_trig_reg < best_trig_reg));
            end
            SM_REARM:
            begin
                rearm_p = pv_reg && p_valid;
            end
            SM_DEDUP:
            begin
                // the outer slot loads the hold; later slots matching it are dropped
                load_hold = pv_reg && (pidx_reg == base_reg);
                clear_p   = twin_match && !load_hold;
            end
            SM_TWIN:
            begin
                clear_p = twin_match;
            end
            SM_FIRE:
            begin
                take_best = pv_reg && p_valid && (rd_trig_reg <= in_now_reg)
                            && (!found_reg || (rd_trig_reg < best_trig_reg)
                                || ((rd_trig_reg == best_trig_reg) && (rd_id_reg < best_id_reg)));
            end
            SM_WAIT:
            begin
                take_best = pv_reg && p_valid && (!found_reg || (rd_trig_reg < best_trig_reg));
            end
            default:
            begin
                take_best = 1'b0;
            end
        endcase
    end

    // one write port shared by add, rearm and fire update
    always_comb
    begin
        trig_we = 1'b0;
        wr_idx  = add_idx;
        wr_trig = key_trig_reg;
        if (cmd.commit_add)
        begin
            trig_we = 1'b1;
        end
        else if (cmd.fire_update)
        begin
            trig_we = 1'b1;
            wr_idx  = best_idx_reg;
            wr_trig = fire_trig_next;
        end
        else if (rearm_p)
        begin
            trig_we = 1'b1;
            wr_idx  = pidx_reg;
            wr_trig = in_now_reg + {32'd0, rd_period_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_add)
        begin
            id_mem[wr_idx]     <= in_id_reg;
            period_mem[wr_idx] <= in_period_reg;
        end
        if (trig_we)
        begin
            trig_mem[wr_idx] <= wr_trig;
        end
        rd_id_reg     <= id_mem[addr_reg];
        rd_period_reg <= period_mem[addr_reg];
        rd_trig_reg   <= trig_mem[addr_reg];
        pidx_reg      <= addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            prev_now_reg <= '0;
        end
        else
        begin
            if (cmd.commit_add)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit_remove)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (clear_p)
            begin
                valid_reg[pidx_reg] <= 1'b0;
            end
            if (cmd.prev_update)
            begin
                prev_now_reg <= in_now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_func_reg   <= in_word.func;
            in_id_reg     <= in_word.timer_id;
            in_period_reg <= in_word.period_ms;
            in_now_reg    <= in_word.now_ms;
            key_trig_reg  <= in_word.now_ms + {32'd0, in_word.period_ms};
        end
        if (take_best)
        begin
            best_idx_reg    <= pidx_reg;
            best_id_reg     <= rd_id_reg;
            best_period_reg <= rd_period_reg;
            best_trig_reg   <= rd_trig_reg;
        end
        if (take_free)
        begin
            free_idx_reg <= pidx_reg;
        end
        if (cmd.fire_update)
        begin
            hold_idx_reg  <= best_idx_reg;
            hold_id_reg   <= best_id_reg;
            hold_trig_reg <= fire_trig_next;
        end
        else if (load_hold)
        begin
            hold_idx_reg  <= pidx_reg;
            hold_id_reg   <= rd_id_reg;
            hold_trig_reg <= rd_trig_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b0;
            addr_reg       <= '0;
            base_reg       <= '0;
            mode_reg       <= SM_ADD;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= run_reg;
            if (cmd.scan_start)
            begin
                run_reg        <= 1'b1;
                addr_reg       <= scan_base;
                base_reg       <= scan_base;
                mode_reg       <= cmd.scan_mode;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    run_reg <= 1'b0;
                end
            end
            if (take_best)
            begin
                found_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.fire_update)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (load_hold)
            begin
                hold_valid_reg <= p_valid;
            end
        end
    end

    assign wait_diff = best_trig_reg - in_now_reg;

    always_comb
    begin
        emit_word        = '0;
        emit_word.kind   = cmd.emit_kind;
        emit_word.status = cmd.emit_status;
        emit_word.last   = cmd.emit_last;
        case (cmd.emit_src)
            SRC_FIRE:
            begin
                emit_word.fired_id = best_id_reg;
            end
            SRC_WAIT:
            begin
                if (!found_reg)
                begin
                    emit_word.wait_ms = NO_TIMER_WAIT;
                end
                else if (best_trig_reg <= in_now_reg)
                begin
                    emit_word.wait_ms = '0;
                end
                else if (wait_diff[63:31] != '0)
                begin
                    emit_word.wait_ms = WAIT_MAX;
                end
                else
                begin
                    emit_word.wait_ms = wait_diff[30:0];
                end
            end
            SRC_ONE:
            begin
                emit_word.wait_ms = 31'd1;
            end
            default:
            begin
                emit_word.fired_id = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign sts.scan_done = pv_reg && (pidx_reg == LAST_IDX);
    // count the slot compared in the last scan cycle as well
    assign sts.found     = found_reg || take_best;
    assign sts.add_ok    = found_reg || free_found_reg;
    assign sts.skew      = prev_now_reg > in_now_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.func      = in_func_reg;

endmodule

// ===== sv/pts_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the timer scheduler: sequences slot scans, commits and result words.
// Depends on pts_pkg; drives pts_dp through cmd_t and reads sts_t.
module pts_ctrl
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int FIRE_CAP    = 31
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_accept,
    input  sts_t  sts,
    output logic  idle,
    output cmd_t  cmd,
    output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] scan_base
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
    localparam logic [4:0] CAP = 5'(FIRE_CAP);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_SCAN,
        S_ADD_EMIT,
        S_REM_SCAN,
        S_REM_EMIT,
        S_REARM,
        S_DEDUP,
        S_SKEW_EMIT,
        S_FIND,
        S_FIRE_EMIT,
        S_FIRE_UPD,
        S_TWIN,
        S_WAIT_SCAN,
        S_WAIT_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] base_next;
    logic [4:0]       fire_cnt_reg;
    logic [4:0]       fire_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = '0;
        base_next     = base_reg;
        fire_cnt_next = fire_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                base_next = '0;
                case (sts.func)
                    FUNC_ADD:
                    begin
                        cmd_next.scan_start = 1'b1;
                        cmd_next.scan_mode  = SM_ADD;
                        state_next          = S_ADD_SCAN;
                    end
                    FUNC_REMOVE:
                    begin
                        cmd_next.scan_start = 1'b1;
                        cmd_next.scan_mode  = SM_REMOVE;
                        state_next          = S_REM_SCAN;
                    end
                    FUNC_TICK:
                    begin
                        cmd_next.prev_update = 1'b1;
                        cmd_next.scan_start  = 1'b1;
                        fire_cnt_next        = '0;
                        if (sts.skew)
                        begin
                            cmd_next.scan_mode = SM_REARM;
                            state_next         = S_REARM;
                        end
                        else
                        begin
                            cmd_next.scan_mode = SM_FIRE;
                            state_next         = S_FIND;
                        end
                    end
                    default:
                    begin
                        // drop unknown function codes
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ADD_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_ADD_EMIT;
                end
            end
            S_ADD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd_next.emit        = 1'b1;
                    cmd_next.emit_src    = SRC_STATUS;
                    cmd_next.emit_kind   = KIND_STATUS;
                    cmd_next.emit_last   = 1'b1;
                    cmd_next.emit_status = sts.add_ok ? STATUS_OK : STATUS_FULL;
                    cmd_next.commit_add  = sts.add_ok;
                    state_next           = S_IDLE;
                end
            end
            S_REM_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_REM_EMIT;
                end
            end
            S_REM_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd_next.emit          = 1'b1;
                    cmd_next.emit_src      = SRC_STATUS;
                    cmd_next.emit_kind     = KIND_STATUS;
                    cmd_next.emit_last     = 1'b1;
                    cmd_next.emit_status   = sts.found ? STATUS_OK : STATUS_NOT_FOUND;
                    cmd_next.commit_remove = sts.found;
                    state_next             = S_IDLE;
                end
            end
            S_REARM:
            begin
                if (sts.scan_done)
                begin
                    base_next           = '0;
                    cmd_next.scan_start = 1'b1;
                    cmd_next.scan_mode  = SM_DEDUP;
                    state_next          = S_DEDUP;
                end
            end
            S_DEDUP:
            begin
                if (sts.scan_done)
                begin
                    if (base_reg == LAST_IDX)
                    begin
                        state_next = S_SKEW_EMIT;
                    end
                    else
                    begin
                        base_next           = base_reg + 1'b1;
                        cmd_next.scan_start = 1'b1;
                        cmd_next.scan_mode  = SM_DEDUP;
                    end
                end
            end
            S_SKEW_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd_next.emit      = 1'b1;
                    cmd_next.emit_src  = SRC_ONE;
                    cmd_next.emit_kind = KIND_WAIT;
                    cmd_next.emit_last = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (sts.scan_done)
                begin
                    if (sts.found)
                    begin
                        state_next = S_FIRE_EMIT;
                    end
                    else
                    begin
                        cmd_next.scan_start = 1'b1;
                        cmd_next.scan_mode  = SM_WAIT;
                        state_next          = S_WAIT_SCAN;
                    end
                end
            end
            S_FIRE_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd_next.emit        = 1'b1;
                    cmd_next.emit_src    = SRC_FIRE;
                    cmd_next.emit_kind   = KIND_FIRED;
                    cmd_next.fire_update = 1'b1;
                    fire_cnt_next        = fire_cnt_reg + 1'b1;
                    state_next           = S_FIRE_UPD;
                end
            end
            S_FIRE_UPD:
            begin
                cmd_next.scan_start = 1'b1;
                cmd_next.scan_mode  = SM_TWIN;
                state_next          = S_TWIN;
            end
            S_TWIN:
            begin
                if (sts.scan_done)
                begin
                    cmd_next.scan_start = 1'b1;
                    if (fire_cnt_reg < CAP)
                    begin
                        cmd_next.scan_mode = SM_FIRE;
                        state_next         = S_FIND;
                    end
                    else
                    begin
                        cmd_next.scan_mode = SM_WAIT;
                        state_next         = S_WAIT_SCAN;
                    end
                end
            end
            S_WAIT_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_WAIT_EMIT;
                end
            end
            S_WAIT_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd_next.emit      = 1'b1;
                    cmd_next.emit_src  = SRC_WAIT;
                    cmd_next.emit_kind = KIND_WAIT;
                    cmd_next.emit_last = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            base_reg     <= '0;
            fire_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            base_reg     <= base_next;
            fire_cnt_reg <= fire_cnt_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign cmd       = cmd_reg;
    assign scan_base = base_reg;

endmodule
